/* design/hbd_pkg.sv */
// Shared types and constants for the Huffman tree-walk decoder.
// Used by hbd_ctrl, hbd_datapath and huffman_bit_decoder; no dependencies.
package hbd_pkg;

  localparam int NODE_COUNT = 512;
  localparam int NODE_AW    = $clog2(NODE_COUNT);
  localparam int IDX_W      = 9;
  localparam int SYM_W      = 8;
  localparam int LEN_W      = 31;
  localparam int ENTRY_W    = SYM_W + 2 * (IDX_W + 1);
  localparam int BYTE_BITS  = 8;
  localparam int CNT_W      = 4;

  localparam logic [1:0] REQ_LOAD   = 2'd0;
  localparam logic [1:0] REQ_DECODE = 2'd1;
  localparam logic [1:0] REQ_FLUSH  = 2'd2;

  localparam logic [1:0] CFG_ROOT_INDEX    = 2'd0;
  localparam logic [1:0] CFG_OUTPUT_LENGTH = 2'd1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_DRAIN
  } state_t;

  typedef struct packed {
    logic accept;  // input transaction taken this cycle
    logic step;    // one tree step on the node read last cycle
    logic drain;   // push the held symbol as the item's last result
  } cmd_t;

  typedef struct packed {
    logic start_walk;   // accepted item produces a walk
    logic stall;        // step must emit but output path is full
    logic walk_end;     // this step finishes the item
    logic pend_valid;   // a symbol is held back
    logic out_free;     // output register can take a symbol
    logic stream_done;  // output_length symbols emitted
  } status_t;

endpackage

/* design/hbd_ctrl.sv */
// Controller state machine of the Huffman tree-walk decoder.
// Depends on hbd_pkg; drives hbd_datapath through cmd_t, reads status_t.
module hbd_ctrl import hbd_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  logic    cfg_valid,
  output logic    cfg_ready,
  input  status_t status,
  output cmd_t    cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    cfg_ready  = 1'b0;
    case (state)
      ST_IDLE: begin
        cfg_ready  = 1'b1;
        // give configuration priority so the two never meet in one cycle
        in_ready   = !cfg_valid;
        cmd.accept = in_valid && !cfg_valid;
        if (cmd.accept && status.start_walk) begin
          state_next = ST_WALK;
        end
      end
      ST_WALK: begin
        cmd.step = 1'b1;
        if (!status.stall && status.walk_end) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        cmd.drain = 1'b1;
        if (!status.pend_valid || status.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

/* design/hbd_datapath.sv */
// Datapath of the Huffman tree-walk decoder: node table, walker registers,
// held symbol and output register. Depends on hbd_pkg; commanded by hbd_ctrl.
module hbd_datapath import hbd_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  cmd_t               cmd,
  output status_t            status,
  input  logic               cfg_write,
  input  logic [1:0]         cfg_index,
  input  logic [LEN_W-1:0]   cfg_data,
  input  logic [1:0]         req_type,
  input  logic [IDX_W-1:0]   node_index,
  input  logic [IDX_W-1:0]   left_child,
  input  logic               has_left,
  input  logic [IDX_W-1:0]   right_child,
  input  logic               has_right,
  input  logic [SYM_W-1:0]   leaf_symbol,
  input  logic [7:0]         data_byte,
  input  logic [CNT_W-1:0]   bit_count,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [SYM_W-1:0]   symbol,
  output logic               last,
  output logic               stream_done
);

  logic [ENTRY_W-1:0] node_mem [NODE_COUNT];
  logic [ENTRY_W-1:0] rd_data;
  logic               rd_ok;
  logic               rd_ok_next;
  logic [NODE_AW-1:0] rd_addr;
  logic               load_we;

  logic [IDX_W-1:0]   root_index;
  logic [LEN_W-1:0]   output_length;
  logic [IDX_W-1:0]   current_node;
  logic [IDX_W-1:0]   current_node_next;
  logic [LEN_W-1:0]   emitted_count;
  logic [LEN_W-1:0]   emitted_inc;

  logic [7:0]         data;
  logic [CNT_W-1:0]   count;
  logic [CNT_W-1:0]   pos;
  logic [CNT_W-1:0]   pos_sum;
  logic               is_flush;

  logic               pend_valid;
  logic [SYM_W-1:0]   pend_symbol;
  logic               pend_done;

  logic [ENTRY_W-1:0] entry;
  logic               bit_val;
  logic [IDX_W-1:0]   child;
  logic               child_has;
  logic               child_ok;
  logic               at_root;
  logic               emit_now;
  logic               out_free;
  logic               stall;
  logic               advance;
  logic               pos_inc;
  logic               hit_length;
  logic               push_mid;
  logic               push_last;

  // node table: one write port for loads, one registered read port
  assign load_we = cmd.accept && (req_type == REQ_LOAD)
                   && ({1'b0, node_index} < (IDX_W + 1)'(NODE_COUNT));

  always_ff @(posedge clk) begin
    if (load_we) begin
      node_mem[node_index[NODE_AW-1:0]] <= {leaf_symbol, has_right, right_child,
                                            has_left, left_child};
    end
    rd_data <= node_mem[rd_addr];
  end

  // step decode on the entry of the current node
  assign entry      = rd_ok ? rd_data : '0;
  assign bit_val    = data[pos[2:0]];
  assign child      = bit_val ? entry[2*IDX_W:IDX_W+1] : entry[IDX_W-1:0];
  assign child_has  = bit_val ? entry[2*IDX_W+1] : entry[IDX_W];
  assign child_ok   = child_has && ({1'b0, child} < (IDX_W + 1)'(NODE_COUNT));
  assign at_root    = (current_node == root_index);
  assign emit_now   = is_flush ? !at_root : !child_ok;
  assign emitted_inc = emitted_count + LEN_W'(1);
  assign hit_length = (emitted_inc == output_length);
  assign out_free   = !out_valid || out_ready;
  assign stall      = emit_now && pend_valid && !out_free;
  assign advance    = cmd.step && !stall;
  // a leaf found at the root still eats the bit
  assign pos_inc    = !is_flush && (child_ok || at_root);
  assign pos_sum    = pos + CNT_W'(pos_inc);
  assign push_mid   = advance && emit_now && pend_valid;
  assign push_last  = cmd.drain && pend_valid && out_free;

  always_comb begin
    current_node_next = current_node;
    if (advance) begin
      current_node_next = (!is_flush && child_ok) ? child : root_index;
    end
  end

  // read the node the walker will stand on next cycle
  assign rd_addr    = current_node_next[NODE_AW-1:0];
  assign rd_ok_next = ({1'b0, current_node_next} < (IDX_W + 1)'(NODE_COUNT));

  always_comb begin
    status.start_walk  = (emitted_count != output_length)
                         && (((req_type == REQ_DECODE) && (bit_count != '0))
                             || (req_type == REQ_FLUSH));
    status.stall       = stall;
    status.walk_end    = is_flush || (pos_sum == count) || (emit_now && hit_length);
    status.pend_valid  = pend_valid;
    status.out_free    = out_free;
    status.stream_done = (emitted_count == output_length);
  end

  // walker and configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      root_index    <= '0;
      output_length <= '0;
      current_node  <= '0;
      emitted_count <= '0;
      rd_ok         <= 1'b0;
    end else begin
      rd_ok <= rd_ok_next;
      if (cfg_write && (cfg_index == CFG_ROOT_INDEX)) begin
        root_index    <= cfg_data[IDX_W-1:0];
        current_node  <= cfg_data[IDX_W-1:0];
        emitted_count <= '0;
      end else if (cfg_write && (cfg_index == CFG_OUTPUT_LENGTH)) begin
        output_length <= cfg_data;
        current_node  <= root_index;
        emitted_count <= '0;
      end else begin
        current_node <= current_node_next;
        if (advance && emit_now) begin
          emitted_count <= emitted_inc;
        end
      end
    end
  end

  // latch the item being walked
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      data     <= data_byte;
      count    <= (bit_count > CNT_W'(BYTE_BITS)) ? CNT_W'(BYTE_BITS) : bit_count;
      pos      <= '0;
      is_flush <= (req_type == REQ_FLUSH);
    end else if (advance) begin
      pos <= pos_sum;
    end
  end

  // hold each symbol back until we know whether it ends the item
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (advance && emit_now) begin
      pend_valid <= 1'b1;
    end else if (push_last) begin
      pend_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit_now) begin
      pend_symbol <= entry[ENTRY_W-1:ENTRY_W-SYM_W];
      pend_done   <= hit_length;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (push_mid || push_last) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push_mid || push_last) begin
      symbol      <= pend_symbol;
      last        <= push_last;
      stream_done <= pend_done;
    end
  end

endmodule

/* design/huffman_bit_decoder.sv */
// Top level of the Huffman tree-walk decoder.
// Depends on hbd_pkg, hbd_ctrl and hbd_datapath.
//
//   channel  handshake               payload
//   -------  ----------------------  ------------------------------------------
//   in       in_valid / in_ready     req_type, node_index, left_child, has_left,
//                                    right_child, has_right, leaf_symbol,
//                                    data_byte, bit_count
//   out      out_valid / out_ready   symbol, last, stream_done
//   cfg      cfg_valid / cfg_ready   cfg_index, cfg_data
//
// Load items and items that give no result are finished in ST_IDLE. Decode and
// flush items go through ST_IDLE, then ST_WALK for S tree steps (bit moves plus
// emissions, at most 16 for 8 bits), then ST_DRAIN; each step is one node table read.
// The node table is not cleared; reset clears the walker, counters, configuration and valid flags.
// Steps that emit stall while a symbol is held and the output register is still full.
module huffman_bit_decoder import hbd_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         req_type,
  input  logic [IDX_W-1:0]   node_index,
  input  logic [IDX_W-1:0]   left_child,
  input  logic               has_left,
  input  logic [IDX_W-1:0]   right_child,
  input  logic               has_right,
  input  logic [SYM_W-1:0]   leaf_symbol,
  input  logic [7:0]         data_byte,
  input  logic [CNT_W-1:0]   bit_count,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [SYM_W-1:0]   symbol,
  output logic               last,
  output logic               stream_done,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [LEN_W-1:0]   cfg_data
);

  cmd_t    cmd;
  status_t status;

  hbd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .status    (status),
    .cmd       (cmd)
  );

  hbd_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .cfg_write   (cfg_valid && cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .req_type    (req_type),
    .node_index  (node_index),
    .left_child  (left_child),
    .has_left    (has_left),
    .right_child (right_child),
    .has_right   (has_right),
    .leaf_symbol (leaf_symbol),
    .data_byte   (data_byte),
    .bit_count   (bit_count),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .symbol      (symbol),
    .last        (last),
    .stream_done (stream_done)
  );

`ifndef ASSERT_OFF
  a_idle_no_pending: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !status.pend_valid)
    else $error("new transaction taken while a symbol is still held");

  a_no_step_after_done: assert property (@(posedge clk) disable iff (rst)
    cmd.step |-> !status.stream_done)
    else $error("tree step after output_length symbols");

  a_drain_marks_last: assert property (@(posedge clk) disable iff (rst)
    (cmd.drain && status.pend_valid && status.out_free) |=> (out_valid && last))
    else $error("held symbol drained without last flag");
`endif

endmodule

/* sim/testbench.sv */
// Self-checking bench for huffman_bit_decoder: builds Huffman trees in the node
// table, streams compressed bytes and checks every decoded symbol in order.
// Depends on hbd_pkg and huffman_bit_decoder.
`timescale 1ns / 100ps

module testbench;
  import hbd_pkg::*;

  localparam logic [1:0] REQ_UNKNOWN  = 2'd3;
  localparam int SETTLE_CYCLES = 40;
  localparam int HOLD_AT       = 60;
  localparam int HOLD_CYCLES   = 300;
  localparam int MAX_REPORTS   = 40;

  typedef struct packed {
    logic [SYM_W-1:0] sym;
    logic             has_r;
    logic [IDX_W-1:0] right;
    logic             has_l;
    logic [IDX_W-1:0] left;
  } tree_node_t;

  typedef struct packed {
    logic [1:0]       kind;
    logic [IDX_W-1:0] idx;
    logic [IDX_W-1:0] lc;
    logic             hl;
    logic [IDX_W-1:0] rc;
    logic             hr;
    logic [SYM_W-1:0] sym;
    logic [7:0]       data;
    logic [CNT_W-1:0] cnt;
  } req_item_t;

  typedef struct packed {
    logic [SYM_W-1:0] sym;
    logic             last;
    logic             done;
  } decoded_t;

  // Tree walker kept in step with the block; queues the symbols each
  // accepted request should produce and checks them as they come out.
  class symbol_scoreboard;
    tree_node_t       node_mem[NODE_COUNT];
    logic [IDX_W-1:0] root_sel;
    logic [IDX_W-1:0] walk_pos;
    logic [LEN_W-1:0] stream_len;
    logic [LEN_W-1:0] sent_count;
    decoded_t         pending_q[$];
    int               errors;

    function new();
      root_sel   = '0;
      walk_pos   = '0;
      stream_len = '0;
      sent_count = '0;
      errors     = 0;
    endfunction

    function int outstanding();
      return pending_q.size();
    endfunction

    // A write to the root-index or output-length register restarts the stream.
    function void write_register(logic [1:0] reg_idx, logic [LEN_W-1:0] value);
      if (reg_idx == CFG_ROOT_INDEX) begin
        root_sel = value[IDX_W-1:0];
      end else if (reg_idx == CFG_OUTPUT_LENGTH) begin
        stream_len = value;
      end else begin
        return;
      end
      walk_pos   = root_sel;
      sent_count = '0;
    endfunction

    function void emit(tree_node_t n);
      decoded_t d;
      sent_count = sent_count + 1'b1;
      d.sym  = n.sym;
      d.last = 1'b0;
      d.done = (sent_count == stream_len);
      pending_q.push_back(d);
      walk_pos = root_sel;
    endfunction

    function void take_item(req_item_t it);
      tree_node_t cur;
      int         bits;
      int         pos;
      int         first;
      logic       at_root;
      logic       b;
      first = pending_q.size();
      if (it.kind == REQ_LOAD) begin
        node_mem[it.idx] = '{sym: it.sym, has_r: it.hr, right: it.rc,
                             has_l: it.hl, left: it.lc};
        return;
      end
      if (sent_count == stream_len) return;
      if (it.kind == REQ_DECODE) begin
        bits = (it.cnt > BYTE_BITS) ? BYTE_BITS : int'(it.cnt);
        pos  = 0;
        while (pos < bits && sent_count != stream_len) begin
          cur = node_mem[walk_pos];
          b   = it.data[pos];
          if (b ? cur.has_r : cur.has_l) begin
            walk_pos = b ? cur.right : cur.left;
            pos++;
          end else begin
            // a leaf at the root eats the bit, elsewhere the bit is retried
            at_root = (walk_pos == root_sel);
            emit(cur);
            if (at_root) pos++;
          end
        end
      end else if (it.kind == REQ_FLUSH && walk_pos != root_sel) begin
        emit(node_mem[walk_pos]);
      end
      if (pending_q.size() > first) pending_q[pending_q.size()-1].last = 1'b1;
    endfunction

    function void compare(string what, logic [SYM_W-1:0] want, logic [SYM_W-1:0] got);
      if (got !== want) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
      end
    endfunction

    function void check_symbol(logic [SYM_W-1:0] s, logic l, logic d);
      decoded_t want;
      if (pending_q.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: symbol %h arrived with nothing expected", $time, s);
        return;
      end
      want = pending_q.pop_front();
      compare("symbol", want.sym, s);
      compare("last", SYM_W'(want.last), SYM_W'(l));
      compare("stream_done", SYM_W'(want.done), SYM_W'(d));
    endfunction
  endclass

  logic             clk;
  logic             rst;
  logic             in_valid;
  logic             in_ready;
  logic [1:0]       req_type;
  logic [IDX_W-1:0] node_index;
  logic [IDX_W-1:0] left_child;
  logic             has_left;
  logic [IDX_W-1:0] right_child;
  logic             has_right;
  logic [SYM_W-1:0] leaf_symbol;
  logic [7:0]       data_byte;
  logic [CNT_W-1:0] bit_count;
  logic             out_valid;
  logic             out_ready;
  logic [SYM_W-1:0] symbol;
  logic             last;
  logic             stream_done;
  logic             cfg_valid;
  logic             cfg_ready;
  logic [1:0]       cfg_index;
  logic [LEN_W-1:0] cfg_data;

  symbol_scoreboard sb = new();

  bit               loaded[NODE_COUNT];
  logic [IDX_W-1:0] loaded_list[$];
  bit               feed_burst;
  bit               drain_burst;
  int               results_seen;

  huffman_bit_decoder dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .req_type    (req_type),
    .node_index  (node_index),
    .left_child  (left_child),
    .has_left    (has_left),
    .right_child (right_child),
    .has_right   (has_right),
    .leaf_symbol (leaf_symbol),
    .data_byte   (data_byte),
    .bit_count   (bit_count),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .symbol      (symbol),
    .last        (last),
    .stream_done (stream_done),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) sb.write_register(cfg_index, cfg_data);
      if (in_valid && in_ready) begin
        sb.take_item('{kind: req_type, idx: node_index, lc: left_child, hl: has_left,
                       rc: right_child, hr: has_right, sym: leaf_symbol,
                       data: data_byte, cnt: bit_count});
      end
      if (out_valid && out_ready) sb.check_symbol(symbol, last, stream_done);
    end
  end

  // Idle cycles before the next transaction; bursts switch idling off for a while.
  function automatic int draw_pause(inout bit burst);
    if ($urandom_range(0, 15) == 0) burst = !burst;
    return burst ? 0 : $urandom_range(0, 9);
  endfunction

  function automatic req_item_t make_req(logic [1:0] kind);
    logic [63:0] noise;
    req_item_t   it;
    noise   = {$urandom, $urandom};
    it      = noise[$bits(req_item_t)-1:0];
    it.kind = kind;
    return it;
  endfunction

  function automatic logic [IDX_W-1:0] pick_loaded();
    return loaded_list[$urandom_range(0, loaded_list.size() - 1)];
  endfunction

  function automatic logic [CNT_W-1:0] pick_count();
    if ($urandom_range(0, 4) == 0) return CNT_W'($urandom_range(0, 15));
    return CNT_W'($urandom_range(1, 8));
  endfunction

  task automatic send_item(input req_item_t it);
    int gap;
    gap = draw_pause(feed_burst);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_type    <= it.kind;
    node_index  <= it.idx;
    left_child  <= it.lc;
    has_left    <= it.hl;
    right_child <= it.rc;
    has_right   <= it.hr;
    leaf_symbol <= it.sym;
    data_byte   <= it.data;
    bit_count   <= it.cnt;
    in_valid    <= 1'b1;
    if (it.kind == REQ_LOAD && !loaded[it.idx]) begin
      loaded[it.idx] = 1'b1;
      loaded_list.push_back(it.idx);
    end
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_load(input logic [IDX_W-1:0] at, input logic [IDX_W-1:0] lc,
                           input logic hl, input logic [IDX_W-1:0] rc, input logic hr,
                           input logic [SYM_W-1:0] s);
    req_item_t it;
    it     = make_req(REQ_LOAD);
    it.idx = at;
    it.lc  = lc;
    it.hl  = hl;
    it.rc  = rc;
    it.hr  = hr;
    it.sym = s;
    send_item(it);
  endtask

  task automatic send_decode(input logic [7:0] d, input logic [CNT_W-1:0] c);
    req_item_t it;
    it      = make_req(REQ_DECODE);
    it.data = d;
    it.cnt  = c;
    send_item(it);
  endtask

  // Drop valid, let every expected symbol drain, then let the walker settle.
  task automatic wait_idle();
    in_valid <= 1'b0;
    // let the monitor note the transaction taken at this edge first
    @(posedge clk);
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_stream(input logic [IDX_W-1:0] top, input logic [LEN_W-1:0] len);
    cfg_index <= CFG_ROOT_INDEX;
    cfg_data  <= LEN_W'(top);
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= CFG_OUTPUT_LENGTH;
    cfg_data  <= len;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // Load a fresh tree bottom-up; every child points at a node already loaded.
  task automatic build_tree(output logic [IDX_W-1:0] top);
    logic [IDX_W-1:0] pool[$];
    bit               taken[NODE_COUNT];
    logic [IDX_W-1:0] a;
    logic [IDX_W-1:0] b;
    logic [IDX_W-1:0] slot;
    int               leaves;
    int               k;
    leaves = $urandom_range(1, 8);
    for (k = 0; k < leaves; k++) begin
      do slot = IDX_W'($urandom); while (taken[slot]);
      taken[slot] = 1'b1;
      send_load(slot, IDX_W'($urandom), 1'b0, IDX_W'($urandom), 1'b0, SYM_W'($urandom));
      pool.push_back(slot);
    end
    while (pool.size() > 1) begin
      k = $urandom_range(0, pool.size() - 1);
      a = pool[k];
      pool.delete(k);
      do slot = IDX_W'($urandom); while (taken[slot]);
      taken[slot] = 1'b1;
      if ($urandom_range(0, 4) == 0) begin
        // one-sided node: the missing branch acts as a leaf
        if ($urandom_range(0, 1) == 1)
          send_load(slot, a, 1'b1, IDX_W'($urandom), 1'b0, SYM_W'($urandom));
        else
          send_load(slot, IDX_W'($urandom), 1'b0, a, 1'b1, SYM_W'($urandom));
      end else begin
        k = $urandom_range(0, pool.size() - 1);
        b = pool[k];
        pool.delete(k);
        send_load(slot, a, 1'b1, b, 1'b1, SYM_W'($urandom));
      end
      pool.push_back(slot);
    end
    top = pool[0];
  endtask

  task automatic run_phase(input logic [LEN_W-1:0] len, input int n_items, input bit pause);
    logic [IDX_W-1:0] top;
    logic [IDX_W-1:0] lc;
    logic [IDX_W-1:0] rc;
    logic             hl;
    logic             hr;
    int               sel;
    int               done_items;
    build_tree(top);
    wait_idle();
    set_stream(top, len);
    done_items = 0;
    while (done_items < n_items) begin
      sel = $urandom_range(0, 99);
      if (sel < 70) begin
        send_decode(8'($urandom), pick_count());
      end else if (sel < 82) begin
        send_item(make_req(REQ_FLUSH));
      end else if (sel < 94) begin
        hl = 1'($urandom);
        hr = 1'($urandom);
        lc = hl ? pick_loaded() : IDX_W'($urandom);
        rc = hr ? pick_loaded() : IDX_W'($urandom);
        send_load(IDX_W'($urandom), lc, hl, rc, hr, SYM_W'($urandom));
      end else begin
        send_item(make_req(REQ_UNKNOWN));
        continue;
      end
      done_items++;
      if (pause && done_items == n_items / 2) wait_idle();
    end
  endtask

  // Receiver: random stalls, plus one long hold-off that backs up the block.
  initial begin : sink
    int gap;
    out_ready    <= 1'b0;
    results_seen = 0;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      gap = draw_pause(drain_burst);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      results_seen++;
      if (results_seen == HOLD_AT) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    rst         <= 1'b1;
    in_valid    <= 1'b0;
    req_type    <= REQ_LOAD;
    node_index  <= '0;
    left_child  <= '0;
    has_left    <= 1'b0;
    right_child <= '0;
    has_right   <= 1'b0;
    leaf_symbol <= '0;
    data_byte   <= '0;
    bit_count   <= '0;
    cfg_valid   <= 1'b0;
    cfg_index   <= CFG_ROOT_INDEX;
    cfg_data    <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // small tree at root 0: bit 0 -> leaf A5, bits 1,0 -> leaf FF, node 2 one-sided
    send_load(9'd1, 9'h1FF, 1'b0, 9'h000, 1'b0, 8'hA5);
    send_load(9'd3, 9'h155, 1'b0, 9'h0AA, 1'b0, 8'hFF);
    send_load(9'd2, 9'd3, 1'b1, 9'h1FF, 1'b0, 8'h3C);
    send_load(9'd0, 9'd1, 1'b1, 9'd2, 1'b1, 8'h00);
    send_load(9'd511, 9'h000, 1'b0, 9'h000, 1'b0, 8'h5A);
    send_item(make_req(REQ_UNKNOWN));
    send_decode(8'hFF, 4'd8);  // stream length still zero: nothing comes out
    wait_idle();

    set_stream(9'd0, {LEN_W{1'b1}});
    send_decode(8'h00, 4'd8);
    send_item(make_req(REQ_FLUSH));
    send_item(make_req(REQ_FLUSH));  // walker at root: no symbol
    send_decode(8'hFF, 4'd8);
    send_decode(8'hA5, 4'd0);
    send_decode(8'h3C, 4'd15);
    send_decode(8'h81, 4'd9);
    send_decode(8'h02, 4'd2);
    send_item(make_req(REQ_FLUSH));
    wait_idle();

    // one-leaf tree: one symbol per bit, stream ends mid-byte
    set_stream(9'd511, 31'd3);
    send_decode(8'hFF, 4'd8);
    send_decode(8'h00, 4'd4);
    send_item(make_req(REQ_FLUSH));
    wait_idle();

    set_stream(9'd0, '0);
    send_decode(8'hFF, 4'd8);
    send_item(make_req(REQ_FLUSH));

    run_phase({LEN_W{1'b1}}, 40, 1'b1);
    run_phase(LEN_W'($urandom_range(15, 40)), 30, 1'b0);
    run_phase(LEN_W'($urandom_range(1, 6)), 12, 1'b0);
    run_phase({LEN_W{1'b1}}, 40, 1'b0);

    wait_idle();
    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
